[hdl/rspe_pkg.sv]
// Shared types, constants and GF(256) arithmetic for the Reed-Solomon parity encoder.
package rspe_pkg;

	localparam int MAX_EC_DEFAULT = 32;
	localparam logic [5:0] NUM_EC_RESET = 6'd10;
	localparam logic [8:0] GF_POLY = 9'h11D;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_data;
	} msg_item_t;

	typedef struct packed {
		logic [7:0] parity_byte;
		logic       last_parity;
	} par_item_t;

	// multiply by alpha, reducing by the field polynomial
	function automatic logic [7:0] gf_xtime(input logic [7:0] a);
		logic [8:0] w;
		w = {a, 1'b0};
		if (w[8]) begin
			w = w ^ GF_POLY;
		end
		return w[7:0];
	endfunction

	// shift-and-add multiply in GF(256)
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			x = gf_xtime(x);
		end
		return acc;
	endfunction

endpackage

[hdl/reed_solomon_parity_encoder.sv]
// Top level of the GF(256) Reed-Solomon parity encoder (poly 0x11D, roots alpha^0..).
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------
//  message   | push / full        | msg_item_t: data_byte, last_data
//  codeword  | pop / empty        | par_item_t: parity_byte, last_parity
//  config    | cfg_we             | cfg_data: num_ec (6 bits)
//
// One data byte is taken per cycle while full is low; the remainder chain updates all taps at once.
// A message yields n parity bytes (n = num_ec clamped to 1..MAX_EC), one per pop.
// After reset and after each num_ec write, full stays high while the
// generator is rebuilt one root factor per cycle.
// Up to two finished frames queue ahead of the emitter; full rises when both are held.
module reed_solomon_parity_encoder #(
	parameter int MAX_EC = rspe_pkg::MAX_EC_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  rspe_pkg::msg_item_t message,
	output logic                empty,
	input  logic                pop,
	output rspe_pkg::par_item_t codeword,
	input  logic                cfg_we,
	input  logic [5:0]          cfg_data
);
	import rspe_pkg::*;

	localparam int NW = $clog2(MAX_EC + 1);

	logic [5:0]             num_ec_q;
	logic [6:0]             n_wide;
	logic [NW-1:0]          n_eff;
	logic                   busy;
	logic [MAX_EC-1:0][7:0] taps;
	logic                   accept;
	logic                   frame_push;
	logic [MAX_EC-1:0][7:0] frame_wr;
	logic [MAX_EC-1:0][7:0] frame_rd;
	logic                   frame_valid;
	logic                   frame_full;
	logic                   frame_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ec_q <= NUM_EC_RESET;
		end else if (cfg_we) begin
			num_ec_q <= cfg_data;
		end
	end

	always_comb begin
		priority if (num_ec_q == 6'd0) begin
			n_wide = 7'd1;
		end else if ({1'b0, num_ec_q} > 7'(MAX_EC)) begin
			n_wide = 7'(MAX_EC);
		end else begin
			n_wide = {1'b0, num_ec_q};
		end
	end

	assign n_eff  = NW'(n_wide);
	assign full   = busy || frame_full;
	assign accept = push && !full;

	rspe_genbuild #(
		.MAX_EC (MAX_EC),
		.NW     (NW)
	) u_genbuild (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_we),
		.n_eff  (n_eff),
		.busy   (busy),
		.taps   (taps)
	);

	rspe_lfsr #(
		.MAX_EC (MAX_EC)
	) u_lfsr (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (message),
		.clear      (cfg_we),
		.taps       (taps),
		.frame_push (frame_push),
		.frame      (frame_wr)
	);

	rspe_frame_fifo #(
		.WIDTH (MAX_EC * 8),
		.DEPTH (2)
	) u_frame_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (frame_push),
		.wr_data (frame_wr),
		.rd_en   (frame_pop),
		.rd_data (frame_rd),
		.valid   (frame_valid),
		.full    (frame_full)
	);

	rspe_emit #(
		.MAX_EC (MAX_EC),
		.NW     (NW)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame       (frame_rd),
		.frame_pop   (frame_pop),
		.n_eff       (n_eff),
		.pop         (pop),
		.empty       (empty),
		.codeword    (codeword)
	);

endmodule

[hdl/rspe_genbuild.sv]
// Generator polynomial rebuild sequencer: one root factor per cycle.
module rspe_genbuild #(
	parameter int MAX_EC = rspe_pkg::MAX_EC_DEFAULT,
	parameter int NW = $clog2(MAX_EC + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NW-1:0]              n_eff,
	output logic                       busy,
	output logic [MAX_EC-1:0][7:0]     taps
);
	import rspe_pkg::*;

	// b_q[k] holds the coefficient of x^(n-k); b[0] is the monic 1 and is not stored
	logic [MAX_EC:1][7:0] b_q;
	logic [MAX_EC:1][7:0] b_nxt;
	logic [7:0]           root_q;
	logic [7:0]           root;
	logic [NW-1:0]        iter_q;
	logic                 busy_q;
	logic                 first;

	assign first = (iter_q == '0);
	assign root  = first ? 8'h01 : root_q;

	// multiply the reversed polynomial by (1 + root*x)
	always_comb begin
		logic [7:0] prev;
		logic [7:0] cur;
		for (int k = 1; k <= MAX_EC; k++) begin
			if (k == 1) begin
				prev = 8'h01;
			end else begin
				prev = first ? 8'h00 : b_q[k-1];
			end
			cur = first ? 8'h00 : b_q[k];
			b_nxt[k] = cur ^ gf_mul(root, prev);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			iter_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			iter_q <= '0;
		end else if (busy_q) begin
			if (iter_q == n_eff - NW'(1)) begin
				busy_q <= 1'b0;
				iter_q <= '0;
			end else begin
				iter_q <= iter_q + NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !start) begin
			b_q    <= b_nxt;
			root_q <= gf_xtime(root);
		end
	end

	assign busy = busy_q;

	always_comb begin
		for (int j = 0; j < MAX_EC; j++) begin
			taps[j] = b_q[j+1];
		end
	end

endmodule

[hdl/rspe_lfsr.sv]
// Front end: remainder chain, one data byte per cycle while accept is high, snapshot on the last byte.
module rspe_lfsr #(
	parameter int MAX_EC = rspe_pkg::MAX_EC_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  rspe_pkg::msg_item_t    item,
	input  logic                   clear,
	input  logic [MAX_EC-1:0][7:0] taps,
	output logic                   frame_push,
	output logic [MAX_EC-1:0][7:0] frame
);
	import rspe_pkg::*;

	logic [MAX_EC-1:0][7:0] rem_q;
	logic [MAX_EC-1:0][7:0] rem_nxt;
	logic [7:0]             fb;

	assign fb = item.data_byte ^ rem_q[0];

	// taps beyond the active count are zero, so the unused tail stays clear
	always_comb begin
		for (int j = 0; j < MAX_EC; j++) begin
			if (j + 1 < MAX_EC) begin
				rem_nxt[j] = rem_q[j+1] ^ gf_mul(fb, taps[j]);
			end else begin
				rem_nxt[j] = gf_mul(fb, taps[j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (clear) begin
			rem_q <= '0;
		end else if (accept) begin
			if (item.last_data) begin
				rem_q <= '0;
			end else begin
				rem_q <= rem_nxt;
			end
		end
	end

	assign frame_push = accept && item.last_data;
	assign frame      = rem_nxt;

endmodule

[hdl/rspe_frame_fifo.sv]
// Short queue of finished parity frames between the remainder chain and the emitter.
module rspe_frame_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             valid,
	output logic             full
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DEPTH-1:0][WIDTH-1:0] mem_q;
	logic [AW-1:0]               wr_ptr_q;
	logic [AW-1:0]               rd_ptr_q;
	logic [CW-1:0]               count_q;
	logic                        do_wr;
	logic                        do_rd;

	assign valid = (count_q != '0);
	assign full  = (count_q == CW'(DEPTH));
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && valid;

	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/rspe_emit.sv]
// Back end: shifts one parity frame out a byte per transaction, highest degree first.
module rspe_emit #(
	parameter int MAX_EC = rspe_pkg::MAX_EC_DEFAULT,
	parameter int NW = $clog2(MAX_EC + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   frame_valid,
	input  logic [MAX_EC-1:0][7:0] frame,
	output logic                   frame_pop,
	input  logic [NW-1:0]          n_eff,
	input  logic                   pop,
	output logic                   empty,
	output rspe_pkg::par_item_t    codeword
);
	import rspe_pkg::*;

	logic [MAX_EC-1:0][7:0] sh_q;
	logic [NW-1:0]          cnt_q;
	logic                   active_q;
	logic                   take;
	logic                   final_byte;
	logic                   load;

	assign final_byte = (cnt_q == NW'(1));
	assign take       = pop && active_q;
	// next frame loads straight behind the final byte of the current one
	assign load       = frame_valid && (!active_q || (take && final_byte));
	assign frame_pop  = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (load) begin
			active_q <= 1'b1;
			cnt_q    <= n_eff;
		end else if (take) begin
			cnt_q <= cnt_q - NW'(1);
			if (final_byte) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q <= frame;
		end else if (take) begin
			for (int j = 0; j < MAX_EC; j++) begin
				sh_q[j] <= (j + 1 < MAX_EC) ? sh_q[j+1] : 8'h00;
			end
		end
	end

	assign empty                = !active_q;
	assign codeword.parity_byte = sh_q[0];
	assign codeword.last_parity = final_byte;

endmodule

[bench/reed_solomon_parity_encoder_test.sv]
// Self-checking bench for the Reed-Solomon parity encoder: directed table, then random messages.
`timescale 1ns / 100ps

module reed_solomon_parity_encoder_test;
	import rspe_pkg::*;

	localparam int MAX_EC       = MAX_EC_DEFAULT;
	localparam int HALF_PERIOD  = 4;
	localparam int RANDOM_BYTES = 130;
	localparam int SETTLE       = MAX_EC + 8;
	localparam int STALL_LIMIT  = 4000;
	localparam int DIRECTED     = 26;

	typedef enum logic [1:0] {
		STEP_CFG,
		STEP_BYTE
	} step_kind_t;

	// typed = every parity byte of this message is known to equal typed_par
	typedef struct packed {
		step_kind_t kind;
		logic [7:0] value;
		logic       last;
		logic       typed;
		logic [7:0] typed_par;
	} step_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	msg_item_t  message;
	logic       empty;
	logic       pop;
	par_item_t  codeword;
	logic       cfg_we;
	logic [5:0] cfg_data;

	// predictor state
	logic [7:0] gen_poly [0:MAX_EC];
	logic [7:0] chain [0:MAX_EC-1];
	int         n_parity;
	par_item_t  parity_due [$];

	int unsigned mismatches;
	int unsigned bytes_in;
	int unsigned stall_cycles;
	bit          calm;

	step_t directed [0:DIRECTED-1] = '{
		'{STEP_BYTE, 8'h00, 1'b1, 1'b1, 8'h00},
		'{STEP_BYTE, 8'hFF, 1'b0, 1'b0, 8'h00},
		'{STEP_BYTE, 8'h00, 1'b0, 1'b0, 8'h00},
		'{STEP_BYTE, 8'h80, 1'b0, 1'b0, 8'h00},
		'{STEP_BYTE, 8'h01, 1'b1, 1'b0, 8'h00},
		'{STEP_CFG,  8'h00, 1'b0, 1'b0, 8'h00},
		'{STEP_BYTE, 8'hFF, 1'b1, 1'b1, 8'hFF},
		'{STEP_BYTE, 8'hA5, 1'b1, 1'b1, 8'hA5},
		'{STEP_CFG,  8'h01, 1'b0, 1'b0, 8'h00},
		'{STEP_BYTE, 8'h5A, 1'b1, 1'b1, 8'h5A},
		'{STEP_BYTE, 8'h12, 1'b0, 1'b0, 8'h00},
		'{STEP_BYTE, 8'h34, 1'b1, 1'b0, 8'h00},
		'{STEP_CFG,  8'h20, 1'b0, 1'b0, 8'h00},
		'{STEP_BYTE, 8'h00, 1'b1, 1'b1, 8'h00},
		'{STEP_BYTE, 8'hFF, 1'b0, 1'b0, 8'h00},
		'{STEP_BYTE, 8'h01, 1'b0, 1'b0, 8'h00},
		'{STEP_BYTE, 8'hFE, 1'b1, 1'b0, 8'h00},
		'{STEP_CFG,  8'h3F, 1'b0, 1'b0, 8'h00},
		'{STEP_BYTE, 8'hC3, 1'b1, 1'b0, 8'h00},
		'{STEP_BYTE, 8'h77, 1'b0, 1'b0, 8'h00},
		// write mid-message: the partial 0x77 must be dropped
		'{STEP_CFG,  8'h0A, 1'b0, 1'b0, 8'h00},
		'{STEP_BYTE, 8'h00, 1'b1, 1'b1, 8'h00},
		'{STEP_CFG,  8'h02, 1'b0, 1'b0, 8'h00},
		'{STEP_BYTE, 8'h3C, 1'b0, 1'b0, 8'h00},
		'{STEP_BYTE, 8'h99, 1'b1, 1'b0, 8'h00},
		'{STEP_CFG,  8'h21, 1'b0, 1'b0, 8'h00}
	};

	reed_solomon_parity_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.message  (message),
		.empty    (empty),
		.pop      (pop),
		.codeword (codeword),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			x = x[7] ? ({x[6:0], 1'b0} ^ GF_POLY[7:0]) : {x[6:0], 1'b0};
		end
		return acc;
	endfunction

	// append one expected codeword transaction
	function automatic void expect_parity(input par_item_t p);
		parity_due = {parity_due, p};
	endfunction

	// clamp the count, rebuild prod (x + alpha^i) and drop any partial message
	function automatic void set_num_ec(input logic [5:0] v);
		logic [7:0] root;
		n_parity = (v == 0) ? 1 : ((v > MAX_EC) ? MAX_EC : int'(v));
		foreach (gen_poly[k]) gen_poly[k] = 8'h00;
		gen_poly[0] = 8'h01;
		root = 8'h01;
		for (int i = 0; i < n_parity; i++) begin
			for (int j = n_parity; j > 0; j--) begin
				gen_poly[j] = field_mul(gen_poly[j], root) ^ gen_poly[j-1];
			end
			gen_poly[0] = field_mul(gen_poly[0], root);
			root = field_mul(root, 8'h02);
		end
		foreach (chain[k]) chain[k] = 8'h00;
	endfunction

	function automatic void take_byte(input msg_item_t m, input bit queue_it);
		logic [7:0] fb;
		par_item_t  due;
		fb = m.data_byte ^ chain[0];
		for (int j = 0; j + 1 < n_parity; j++) begin
			chain[j] = chain[j+1] ^ field_mul(fb, gen_poly[n_parity-1-j]);
		end
		chain[n_parity-1] = field_mul(fb, gen_poly[0]);
		if (m.last_data) begin
			for (int j = 0; j < n_parity; j++) begin
				due.parity_byte = chain[j];
				due.last_parity = (j == n_parity - 1);
				if (queue_it) begin
					expect_parity(due);
				end
			end
			foreach (chain[k]) chain[k] = 8'h00;
		end
	endfunction

	// called and returns at a falling edge
	task automatic drive_byte(input logic [7:0] d, input logic l, input bit predicted);
		msg_item_t m;
		m.data_byte = d;
		m.last_data = l;
		calm = (bytes_in >= 70 && bytes_in < 120);
		while (!calm && $urandom_range(0, 99) < 19) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		message <= m;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		take_byte(m, predicted);
		bytes_in++;
		@(negedge clk);
	endtask

	task automatic write_num_ec(input logic [5:0] v);
		push <= 1'b0;
		while (parity_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		set_num_ec(v);
	endtask

	always @(negedge clk) begin
		pop <= calm || ($urandom_range(0, 99) >= 19);
	end

	always @(posedge clk) begin
		par_item_t want;
		if (arst_n && pop && !empty) begin
			if (parity_due.size() == 0) begin
				$error("unexpected codeword transaction: parity_byte=%02h last_parity=%0b",
					codeword.parity_byte, codeword.last_parity);
				mismatches++;
			end else begin
				want = parity_due.pop_front();
				if (codeword.parity_byte !== want.parity_byte) begin
					$error("parity_byte: expected %02h, got %02h",
						want.parity_byte, codeword.parity_byte);
					mismatches++;
				end
				if (codeword.last_parity !== want.last_parity) begin
					$error("last_parity: expected %0b, got %0b",
						want.last_parity, codeword.last_parity);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || cfg_we) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		step_t       row;
		par_item_t   due;
		logic [5:0]  v;
		int unsigned pick;
		int unsigned msgs;
		int unsigned len;
		int unsigned start_count;

		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		message = '0;
		pop = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		bytes_in = 0;
		stall_cycles = 0;
		calm = 1'b0;
		set_num_ec(NUM_EC_RESET);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			row = directed[i];
			if (row.kind == STEP_CFG) begin
				write_num_ec(row.value[5:0]);
			end else begin
				drive_byte(row.value, row.last, !row.typed);
				if (row.typed && row.last) begin
					for (int j = 0; j < n_parity; j++) begin
						due.parity_byte = row.typed_par;
						due.last_parity = (j == n_parity - 1);
						expect_parity(due);
					end
				end
			end
		end

		start_count = bytes_in;
		while (bytes_in - start_count < RANDOM_BYTES) begin
			pick = $urandom_range(0, 9);
			unique case (pick)
				0: v = 6'd0;
				1: v = 6'd63;
				2: v = 6'd32;
				3: v = 6'($urandom_range(33, 63));
				default: v = 6'($urandom_range(1, 16));
			endcase
			write_num_ec(v);
			msgs = $urandom_range(2, 6);
			repeat (msgs) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				for (int k = 0; k < len; k++) begin
					drive_byte(8'($urandom), (k == len - 1), 1'b1);
				end
			end
			// sometimes leave a message unfinished; the next write abandons it
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 4)) drive_byte(8'($urandom), 1'b0, 1'b1);
			end
		end

		push <= 1'b0;
		while (parity_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(negedge clk);

		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[reed_solomon_parity_encoder.f]
hdl/rspe_pkg.sv
hdl/rspe_genbuild.sv
hdl/rspe_lfsr.sv
hdl/rspe_frame_fifo.sv
hdl/rspe_emit.sv
hdl/reed_solomon_parity_encoder.sv
bench/reed_solomon_parity_encoder_test.sv
